// ===== rtl/core/rmw_pkg.sv =====
// shared types and constants of the raster to mcu address walker
package rmw_pkg;

  // configuration port address width (seven registers at 4-byte spacing)
  localparam int CFG_ADDR_W = 5;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // field widths
  localparam int PIXEL_W = 24;
  localparam int INDEX_W = 32;
  localparam int COUNT_W = 32;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [4:0]  mw;
    logic [4:0]  mh;
    logic [8:0]  mcu_pixels;
    logic [12:0] na;
    logic [12:0] nd;
  } cfg_t;

  // one classified position handed from front to back
  typedef struct packed {
    logic [11:0]        mcu_row;
    logic [11:0]        mcu_col;
    logic [3:0]         line_in_mcu;
    logic [3:0]         col_in_mcu;
    logic [COUNT_W-1:0] raster_pos;
    logic               in_image;
    logic [PIXEL_W-1:0] pixel_out;
    logic               last;
  } item_t;

endpackage

// ===== rtl/core/rmw_cfg.sv =====
// configuration registers with apb-style access and effective value clamping
module rmw_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rmw_pkg::cfg_t                 cfg
);
  import rmw_pkg::*;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MCU_WIDTH    = 3'd2,
    REG_MCU_HEIGHT   = 3'd3,
    REG_MCU_PIXELS   = 3'd4,
    REG_MCUS_ACROSS  = 3'd5,
    REG_MCUS_DOWN    = 3'd6
  } reg_idx_t;

  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [4:0]  mcu_width;
  logic [4:0]  mcu_height;
  logic [8:0]  mcu_pixels;
  logic [12:0] mcus_across;
  logic [12:0] mcus_down;
  reg_idx_t    idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd8;
      image_height <= 16'd8;
      mcu_width    <= 5'd8;
      mcu_height   <= 5'd8;
      mcu_pixels   <= 9'd64;
      mcus_across  <= 13'd1;
      mcus_down    <= 13'd1;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[15:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[15:0];
        REG_MCU_WIDTH:    mcu_width    <= pwdata[4:0];
        REG_MCU_HEIGHT:   mcu_height   <= pwdata[4:0];
        REG_MCU_PIXELS:   mcu_pixels   <= pwdata[8:0];
        REG_MCUS_ACROSS:  mcus_across  <= pwdata[12:0];
        REG_MCUS_DOWN:    mcus_down    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = {16'b0, image_width};
      REG_IMAGE_HEIGHT: prdata = {16'b0, image_height};
      REG_MCU_WIDTH:    prdata = {27'b0, mcu_width};
      REG_MCU_HEIGHT:   prdata = {27'b0, mcu_height};
      REG_MCU_PIXELS:   prdata = {23'b0, mcu_pixels};
      REG_MCUS_ACROSS:  prdata = {19'b0, mcus_across};
      REG_MCUS_DOWN:    prdata = {19'b0, mcus_down};
      default:          prdata = 32'b0;
    endcase
  end

  // zero mcu sizes and counts act as one, oversized ones clamp to the max
  always_comb begin
    cfg.image_width  = image_width;
    cfg.image_height = image_height;
    cfg.mcu_pixels   = mcu_pixels;
    if (mcu_width == 5'd0) cfg.mw = 5'd1;
    else if (mcu_width > 5'd16) cfg.mw = 5'd16;
    else cfg.mw = mcu_width;
    if (mcu_height == 5'd0) cfg.mh = 5'd1;
    else if (mcu_height > 5'd16) cfg.mh = 5'd16;
    else cfg.mh = mcu_height;
    if (mcus_across == 13'd0) cfg.na = 13'd1;
    else if (mcus_across > 13'd4096) cfg.na = 13'd4096;
    else cfg.na = mcus_across;
    if (mcus_down == 13'd0) cfg.nd = 13'd1;
    else if (mcus_down > 13'd4096) cfg.nd = 13'd4096;
    else cfg.nd = mcus_down;
  end

endmodule

// ===== rtl/core/rmw_front.sv =====
// front end: grid walker that classifies each request and advances the counters
module rmw_front (
  input  logic                       clk,
  input  logic                       rst,
  input  rmw_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic [rmw_pkg::PIXEL_W-1:0] next_pixel,
  output rmw_pkg::item_t             item
);
  import rmw_pkg::*;

  logic [11:0]        mcu_row;
  logic [3:0]         line_in_mcu;
  logic [11:0]        mcu_col;
  logic [3:0]         col_in_mcu;
  logic [COUNT_W-1:0] raster_count;

  logic [16:0] col_pos;
  logic [31:0] area;
  logic        in_img;
  logic        fc, fm, fl, fr;

  // position classification
  assign col_pos = ({5'b0, mcu_col} * {12'b0, cfg.mw}) + {13'b0, col_in_mcu};
  assign area    = {16'b0, cfg.image_width} * {16'b0, cfg.image_height};
  assign in_img  = (col_pos < {1'b0, cfg.image_width}) && (raster_count < area);

  // end of each counter, out-of-range counters count as final
  assign fc = ({1'b0, col_in_mcu} + 5'd1) >= cfg.mw;
  assign fm = ({1'b0, mcu_col} + 13'd1) >= cfg.na;
  assign fl = ({1'b0, line_in_mcu} + 5'd1) >= cfg.mh;
  assign fr = ({1'b0, mcu_row} + 13'd1) >= cfg.nd;

  always_comb begin
    item.mcu_row     = mcu_row;
    item.mcu_col     = mcu_col;
    item.line_in_mcu = line_in_mcu;
    item.col_in_mcu  = col_in_mcu;
    item.raster_pos  = raster_count;
    item.in_image    = in_img;
    item.pixel_out   = in_img ? next_pixel : '0;
    item.last        = fc && fm && fl && fr;
  end

  // walk order: column in mcu, mcu column, line in mcu, mcu row
  always_ff @(posedge clk) begin
    if (rst) begin
      mcu_row      <= '0;
      line_in_mcu  <= '0;
      mcu_col      <= '0;
      col_in_mcu   <= '0;
      raster_count <= '0;
    end else if (accept) begin
      if (in_img && !item.last) raster_count <= raster_count + 32'd1;
      if (!fc) begin
        col_in_mcu <= col_in_mcu + 4'd1;
      end else begin
        col_in_mcu <= '0;
        if (!fm) begin
          mcu_col <= mcu_col + 12'd1;
        end else begin
          mcu_col <= '0;
          if (!fl) begin
            line_in_mcu <= line_in_mcu + 4'd1;
          end else begin
            line_in_mcu <= '0;
            if (!fr) begin
              mcu_row <= mcu_row + 12'd1;
            end else begin
              mcu_row      <= '0;
              raster_count <= '0;
            end
          end
        end
      end
    end
  end

  // the final position brings every counter back to zero
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && item.last |=> mcu_row == 12'd0 && mcu_col == 12'd0 &&
      line_in_mcu == 4'd0 && col_in_mcu == 4'd0 && raster_count == '0)
    else $error("walker did not wrap after last position");

  // raster position moves only on an in-image request or at the wrap after the last position
  a_raster_step: assert property (@(posedge clk) disable iff (rst)
    accept && !item.in_image && !item.last |=> $stable(raster_count))
    else $error("raster count moved on a padding position");

endmodule

// ===== rtl/core/rmw_queue.sv =====
// short queue of classified positions between front and back
module rmw_queue #(
  parameter int DEPTH = rmw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rmw_pkg::item_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output rmw_pkg::item_t rd_data,
  output logic           empty
);
  import rmw_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

  // fill count tracks the pointers
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + CW'(1))
    else $error("queue count did not grow on a write");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/rmw_back.sv =====
// back end: mcu index arithmetic over stage one and the result register
module rmw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rmw_pkg::cfg_t               cfg,
  input  rmw_pkg::item_t              q_data,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [rmw_pkg::INDEX_W-1:0] mcu_index,
  output logic [rmw_pkg::COUNT_W-1:0] raster_pos,
  output logic                        in_image,
  output logic [rmw_pkg::PIXEL_W-1:0] pixel_out,
  output logic                        last
);
  import rmw_pkg::*;

  logic        s1_valid;
  item_t       s1_item;
  logic [24:0] s1_base;
  logic [8:0]  s1_offs;
  logic        out_valid;
  logic        out_load;
  logic        s1_move;
  logic [33:0] index_full;

  assign empty    = !out_valid;
  assign out_load = !out_valid || pop;
  assign s1_move  = s1_valid && out_load;
  assign q_pop    = !q_empty && (!s1_valid || out_load);

  // mcu number times stride plus offset inside the mcu
  assign index_full = ({9'b0, s1_base} * {25'b0, cfg.mcu_pixels}) + {25'b0, s1_offs};

  // stage one: mcu number and offset inside the mcu
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item <= q_data;
      s1_base <= ({13'b0, q_data.mcu_row} * {12'b0, cfg.na}) + {13'b0, q_data.mcu_col};
      s1_offs <= ({5'b0, q_data.line_in_mcu} * {4'b0, cfg.mw}) + {5'b0, q_data.col_in_mcu};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      mcu_index  <= index_full[INDEX_W-1:0];
      raster_pos <= s1_item.raster_pos;
      in_image   <= s1_item.in_image;
      pixel_out  <= s1_item.pixel_out;
      last       <= s1_item.last;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // a stalled stage one keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid && $stable(s1_base) && $stable(s1_offs))
    else $error("stage one lost a stalled request");

endmodule

// ===== rtl/core/raster_to_mcu_address_walker_top.sv =====
// top level of the raster to mcu address walker
// Walks the mcu-padded image grid in the order mcu row, line in mcu, mcu column, column in
// mcu, one position per pushed pixel, and returns the mcu-order index, the raster position,
// the in-image flag, the pixel or zero padding, and a last flag; counters wrap after the last
// position. One position is accepted every clock while the result side keeps popping: the
// front walker updates all counters together on an accepted push. The queue is written at
// the edge that accepts the push; the request then passes the index stage and the result
// register to the outputs, and a stall on the result side holds it. Registers may be
// written only while no request is in flight.
module raster_to_mcu_address_walker_top #(
  parameter int QUEUE_DEPTH = rmw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rmw_pkg::PIXEL_W-1:0]    next_pixel,
  output logic                          empty,
  input  logic                          pop,
  output logic [rmw_pkg::INDEX_W-1:0]    mcu_index,
  output logic [rmw_pkg::COUNT_W-1:0]    raster_pos,
  output logic                          in_image,
  output logic [rmw_pkg::PIXEL_W-1:0]    pixel_out,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rmw_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t q_data;
  logic  accept;
  logic  q_empty;
  logic  q_pop;

  assign accept = push && !full;

  // configuration registers
  rmw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // grid walker
  rmw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .next_pixel (next_pixel),
    .item       (front_item)
  );

  // decoupling queue
  rmw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // index arithmetic and result register
  rmw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .mcu_index  (mcu_index),
    .raster_pos (raster_pos),
    .in_image   (in_image),
    .pixel_out  (pixel_out),
    .last       (last)
  );

endmodule
